/* src/assert_macros.svh */
// Shared assertion macros for the conflict checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define PTCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PTCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ptcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ptcc_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] CMD_ADD_ONE = 2'd0;
  localparam logic [1:0] CMD_ADD_PER = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] start_time;
    logic [30:0] end_time;
    logic [30:0] repeat_period;
    logic [30:0] horizon;
  } in_word_t;

  typedef struct packed {
    logic conflict_found;
    logic overflow_seen;
  } out_word_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] period;
    logic [15:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load_add;
    logic set_ovf;
    logic chk_init;
    logic rd_parent;
    logic up_move;
    logic write_item;
    logic rd_top;
    logic take_top;
    logic rd_last;
    logic load_last;
    logic rd_children;
    logic down_move;
    logic load_push;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_check;
    logic full;
    logic i_zero;
    logic up_before;
    logic count_zero;
    logic count_one;
    logic top_below_h;
    logic no_left;
    logic down_stay;
    logic conflict;
    logic tp_nonzero;
    logic out_pending;
  } dp_stat_t;

  // Heap order: earlier start first, then lower insertion tag.
  function automatic logic ranks_first(input entry_t a, input entry_t b);
    logic r;
    if (a.start_time != b.start_time) begin
      r = a.start_time < b.start_time;
    end else begin
      r = a.order < b.order;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/periodic_task_conflict_checker.sv */
// Periodic task conflict checker.
// Input words carry a command: add a one-shot task, add a periodic task, or
// run a check up to the given horizon. Adds give no result word; a check gives
// one word with the conflict and overflow flags, and then leaves the heap empty.
// Both channels are valid/ready. The block takes one word at a time: an add
// climbs the heap one level per parent read and compare, and an add to a
// full heap only sets the overflow flag.
// A check pops, earliest first, each task that starts before the horizon
// until a conflict is seen, and pushes each periodic task back moved on by
// its period; it runs as a loop around the single heap memory with registered reads.
// The result sits in an output register; if the receiver stalls, adds ahead
// of a later check are accepted as usual, and that check runs its walk and
// then waits at its final step, holding the input off, until the previous
// word is taken.
// Reset empties the heap and clears the order counter and overflow flag; heap
// contents need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_conflict_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptcc_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptcc_pkg::out_word_t     out_data
);
  import ptcc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptcc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* src/ptcc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* src/ptcc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptcc_pkg::dp_stat_t stat,
  output ptcc_pkg::dp_cmd_t      cmd
);
  import ptcc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_SIFT_UP   = 10'b0000000010,
    S_UP_CMP    = 10'b0000000100,
    S_CHK_RD    = 10'b0000001000,
    S_CHK_TOP   = 10'b0000010000,
    S_POP_LAST  = 10'b0000100000,
    S_DOWN_RD   = 10'b0001000000,
    S_DOWN_CMP  = 10'b0010000000,
    S_AFTER_POP = 10'b0100000000,
    S_FINISH    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   chk_mode_r, chk_mode_nxt;
  state_t ret_state;

  assign ret_state = chk_mode_r ? S_CHK_RD : S_IDLE;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    chk_mode_nxt = chk_mode_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_add) begin
            chk_mode_nxt = 1'b0;
            if (stat.full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              cmd.load_add = 1'b1;
              state_nxt    = S_SIFT_UP;
            end
          end else if (stat.is_check) begin
            cmd.chk_init = 1'b1;
            chk_mode_nxt = 1'b1;
            state_nxt    = S_CHK_RD;
          end
        end
      end
      S_SIFT_UP: begin
        if (stat.i_zero) begin
          cmd.write_item = 1'b1;
          state_nxt      = ret_state;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_before) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_SIFT_UP;
        end else begin
          cmd.write_item = 1'b1;
          state_nxt      = ret_state;
        end
      end
      S_CHK_RD: begin
        if (stat.count_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_CHK_TOP;
        end
      end
      S_CHK_TOP: begin
        if (!stat.top_below_h) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.take_top = 1'b1;
          if (stat.count_one) begin
            state_nxt = S_AFTER_POP;
          end else begin
            cmd.rd_last = 1'b1;
            state_nxt   = S_POP_LAST;
          end
        end
      end
      S_POP_LAST: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_DOWN_RD;
      end
      S_DOWN_RD: begin
        if (stat.no_left) begin
          cmd.write_item = 1'b1;
          state_nxt      = S_AFTER_POP;
        end else begin
          cmd.rd_children = 1'b1;
          state_nxt       = S_DOWN_CMP;
        end
      end
      S_DOWN_CMP: begin
        if (stat.down_stay) begin
          cmd.write_item = 1'b1;
          state_nxt      = S_AFTER_POP;
        end else begin
          cmd.down_move = 1'b1;
          state_nxt     = S_DOWN_RD;
        end
      end
      S_AFTER_POP: begin
        // A conflict ends the walk; the heap is discarded anyway.
        if (stat.conflict) begin
          state_nxt = S_FINISH;
        end else if (stat.tp_nonzero) begin
          cmd.load_push = 1'b1;
          state_nxt     = S_SIFT_UP;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_FINISH: begin
        if (!stat.out_pending) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chk_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      chk_mode_r <= chk_mode_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/ptcc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptcc_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptcc_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptcc_pkg::out_word_t     out_data,
  input  wire ptcc_pkg::dp_cmd_t  cmd,
  output ptcc_pkg::dp_stat_t      stat
);
  import ptcc_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      ic_r, ic_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;
  entry_t           item_r, item_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [31:0]      h_r, h_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             conf_r, conf_nxt;
  logic [31:0]      ts_r, ts_nxt, te_r, te_nxt, tp_r, tp_nxt;

  entry_t           rd_a, rd_b, wdata, best;
  logic [ENTRY_W-1:0] rdata_a, rdata_b;
  logic             we;
  logic [IDX_W-1:0] raddr_a, raddr_b, parent, last_idx;
  logic [CNT_W:0]   l_full, r_full;
  logic             pick_l, pick_r;
  logic [32:0]      sum_s, sum_e;

  assign rd_a = entry_t'(rdata_a);
  assign rd_b = entry_t'(rdata_b);

  assign parent   = IDX_W'((i_r - 1'b1) >> 1);
  assign last_idx = IDX_W'(count_r - 1'b1);
  assign l_full   = {1'b0, i_r, 1'b1};
  assign r_full   = l_full + 1'b1;

  // Children choice: left first, then right against the best so far.
  always_comb begin
    pick_l = ranks_first(rd_a, item_r);
    best   = pick_l ? rd_a : item_r;
    pick_r = (r_full < {1'b0, count_r}) && ranks_first(rd_b, best);
    if (pick_r) begin
      best = rd_b;
    end
  end

  assign sum_s = {1'b0, ts_r} + {1'b0, tp_r};
  assign sum_e = {1'b0, te_r} + {1'b0, tp_r};

  always_comb begin
    priority if (cmd.rd_parent) begin
      raddr_a = parent;
    end else if (cmd.rd_top) begin
      raddr_a = '0;
    end else if (cmd.rd_last) begin
      raddr_a = last_idx;
    end else if (cmd.rd_children) begin
      raddr_a = IDX_W'(l_full);
    end else begin
      raddr_a = '0;
    end
  end
  assign raddr_b = IDX_W'(r_full);

  assign we = cmd.write_item | cmd.up_move | cmd.down_move;
  always_comb begin
    priority if (cmd.write_item) begin
      wdata = item_r;
    end else if (cmd.up_move) begin
      wdata = rd_a;
    end else begin
      wdata = best;
    end
  end

  ptcc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (i_r),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_comb begin
    count_nxt     = count_r;
    ic_nxt        = ic_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    item_nxt      = item_r;
    i_nxt         = i_r;
    h_nxt         = h_r;
    now_nxt       = now_r;
    conf_nxt      = conf_r;
    ts_nxt        = ts_r;
    te_nxt        = te_r;
    tp_nxt        = tp_r;
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.load_add) begin
      item_nxt.start_time = {1'b0, in_data.start_time};
      item_nxt.end_time   = {1'b0, in_data.end_time};
      item_nxt.period     = (in_data.command == CMD_ADD_PER) ?
                            {1'b0, in_data.repeat_period} : 32'd0;
      item_nxt.order      = ic_r;
      ic_nxt              = ic_r + 16'd1;
      i_nxt               = IDX_W'(count_r);
      count_nxt           = count_r + 1'b1;
    end
    if (cmd.load_push) begin
      item_nxt.start_time = sum_s[32] ? 32'hFFFF_FFFF : sum_s[31:0];
      item_nxt.end_time   = sum_e[32] ? 32'hFFFF_FFFF : sum_e[31:0];
      item_nxt.period     = tp_r;
      item_nxt.order      = ic_r;
      ic_nxt              = ic_r + 16'd1;
      i_nxt               = IDX_W'(count_r);
      count_nxt           = count_r + 1'b1;
    end
    if (cmd.chk_init) begin
      h_nxt    = {1'b0, in_data.horizon};
      now_nxt  = '0;
      conf_nxt = 1'b0;
    end
    if (cmd.up_move) begin
      i_nxt = parent;
    end
    if (cmd.take_top) begin
      ts_nxt    = rd_a.start_time;
      te_nxt    = rd_a.end_time;
      tp_nxt    = rd_a.period;
      conf_nxt  = rd_a.start_time < now_r;
      now_nxt   = rd_a.end_time;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.load_last) begin
      item_nxt = rd_a;
      i_nxt    = '0;
    end
    if (cmd.down_move) begin
      i_nxt = pick_r ? IDX_W'(r_full) : IDX_W'(l_full);
    end
    if (cmd.finish) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.conflict_found = conf_r;
      out_data_nxt.overflow_seen  = ovf_r;
      count_nxt                   = '0;
      ic_nxt                      = '0;
      ovf_nxt                     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ic_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ic_r        <= ic_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    i_r        <= i_nxt;
    h_r        <= h_nxt;
    now_r      <= now_nxt;
    conf_r     <= conf_nxt;
    ts_r       <= ts_nxt;
    te_r       <= te_nxt;
    tp_r       <= tp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.is_add      = (in_data.command == CMD_ADD_ONE) || (in_data.command == CMD_ADD_PER);
    stat.is_check    = (in_data.command == CMD_CHECK);
    stat.full        = (count_r == CNT_W'(HEAP_DEPTH));
    stat.i_zero      = (i_r == '0);
    stat.up_before   = ranks_first(item_r, rd_a);
    stat.count_zero  = (count_r == '0);
    stat.count_one   = (count_r == CNT_W'(1));
    stat.top_below_h = rd_a.start_time < h_r;
    stat.no_left     = (l_full >= {1'b0, count_r});
    stat.down_stay   = ~pick_l & ~pick_r;
    stat.conflict    = conf_r;
    stat.tp_nonzero  = (tp_r != '0);
    stat.out_pending = out_valid_r & ~out_ready;
  end

endmodule
`default_nettype wire

/* src/ptcc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ptcc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire ptcc_pkg::in_word_t in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ptcc_pkg::out_word_t out_data
);
  import ptcc_pkg::*;

  logic add_acc, chk_acc;
  assign add_acc = in_valid && in_ready &&
                   (in_data.command == CMD_ADD_ONE || in_data.command == CMD_ADD_PER);
  assign chk_acc = in_valid && in_ready && (in_data.command == CMD_CHECK);

  `PTCC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out word dropped")
  `PTCC_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "out word changed")
  `PTCC_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "out valid after reset")
  `PTCC_ASSERT(a_add_silent, clk, rst_n, add_acc && !out_valid |=> !out_valid, "add made a word")
  `PTCC_ASSERT(a_chk_busy, clk, rst_n, chk_acc |=> !in_ready, "ready during check")

endmodule

bind periodic_task_conflict_checker ptcc_checker u_ptcc_checker (.*);
`default_nettype wire
